>>> sv/hevcnal_pkg.sv
// shared types, constants and record builder for the annex b nal splitter
// no dependencies
package hevcnal_pkg;

  localparam int OFS_BITS = 32;

  typedef logic [OFS_BITS-1:0] ofs_t;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [2:0] PREFIX_SHORT = 3'd3;
  localparam logic [2:0] PREFIX_LONG  = 3'd4;
  localparam logic [5:0] TYPE_VPS   = 6'd32;
  localparam logic [5:0] TYPE_SPS   = 6'd33;
  localparam logic [5:0] TYPE_PPS   = 6'd34;
  localparam logic [5:0] TYPE_IRAP_LO = 6'd19;
  localparam logic [5:0] TYPE_IRAP_MID = 6'd20;
  localparam logic [5:0] TYPE_IRAP_HI = 6'd21;

  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_size;
    logic [2:0]  prefix_len;
    logic [5:0]  unit_type;
    logic        is_param_set;
    logic        is_key_frame;
    logic        is_first_slice;
    logic        at_buffer_start;
    logic        end_of_buffer;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } rec_push_t;

  function automatic rec_t make_rec(ofs_t start, ofs_t stop, logic [2:0] prefix,
                                    logic [5:0] kind, logic sflag, logic eob);
    rec_t r;
    ofs_t size;
    size = stop - start;
    r.unit_offset     = 32'(start);
    r.unit_size       = 32'(size);
    r.prefix_len      = prefix;
    r.unit_type       = kind;
    r.is_param_set    = (kind == TYPE_VPS) || (kind == TYPE_SPS) || (kind == TYPE_PPS);
    r.is_key_frame    = (kind == TYPE_IRAP_LO) || (kind == TYPE_IRAP_MID) ||
                        (kind == TYPE_IRAP_HI);
    r.is_first_slice  = (kind <= TYPE_IRAP_HI) && sflag &&
                        (size >= ofs_t'({1'b0, prefix} + 4'd3));
    r.at_buffer_start = (start == '0);
    r.end_of_buffer   = eob;
    return r;
  endfunction

endpackage

>>> sv/hevcnal_scan.sv
// start code scanner: per-byte state update and record generation
// depends on hevcnal_pkg
module hevcnal_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output hevcnal_pkg::rec_push_t push_a,
  output hevcnal_pkg::rec_push_t push_b
);
  import hevcnal_pkg::*;

  ofs_t       byte_offset, byte_offset_next;
  logic [1:0] zero_run, zero_run_next;
  logic       pending_code, pending_code_next;
  ofs_t       pending_start, pending_start_next;
  logic [2:0] pending_prefix, pending_prefix_next;
  logic       unit_active, unit_active_next;
  ofs_t       unit_start, unit_start_next;
  logic [2:0] unit_prefix, unit_prefix_next;
  logic [5:0] unit_kind, unit_kind_next;
  logic [1:0] payload_count, payload_count_next;
  logic       slice_flag_bit, slice_flag_bit_next;
  logic [2:0] pre;
  logic       is_code;

  always_comb begin
    pre = (zero_run == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
    is_code = (data_byte == BYTE_ONE) && (zero_run >= 2'd2) && !last_byte;

    push_a.valid = go && pending_code && unit_active;
    push_a.rec   = make_rec(unit_start, pending_start, unit_prefix, unit_kind,
                            slice_flag_bit, 1'b0);

    unit_active_next    = unit_active || pending_code;
    unit_start_next     = pending_code ? pending_start : unit_start;
    unit_prefix_next    = pending_code ? pending_prefix : unit_prefix;
    unit_kind_next      = pending_code ? data_byte[6:1] : unit_kind;
    payload_count_next  = pending_code ? 2'd0 : payload_count;
    slice_flag_bit_next = pending_code ? 1'b0 : slice_flag_bit;

    if (unit_active_next) begin
      if (payload_count_next == 2'd2) begin
        slice_flag_bit_next = data_byte[7];
      end
      if (payload_count_next != 2'd3) begin
        payload_count_next = payload_count_next + 2'd1;
      end
    end

    pending_code_next   = 1'b0;
    pending_start_next  = pending_start;
    pending_prefix_next = pending_prefix;
    if (data_byte == BYTE_ZERO) begin
      zero_run_next = (zero_run == 2'd3) ? zero_run : zero_run + 2'd1;
    end else begin
      zero_run_next = 2'd0;
      if (is_code) begin
        pending_code_next   = 1'b1;
        pending_prefix_next = pre;
        pending_start_next  = byte_offset - ofs_t'(pre - 3'd1);
      end
    end

    push_b.valid = go && last_byte && unit_active_next;
    push_b.rec   = make_rec(unit_start_next, byte_offset + ofs_t'(1), unit_prefix_next,
                            unit_kind_next, slice_flag_bit_next, 1'b1);

    byte_offset_next = byte_offset + ofs_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || (go && last_byte)) begin
      byte_offset    <= '0;
      zero_run       <= 2'd0;
      pending_code   <= 1'b0;
      pending_start  <= '0;
      pending_prefix <= PREFIX_SHORT;
      unit_active    <= 1'b0;
      unit_start     <= '0;
      unit_prefix    <= PREFIX_SHORT;
      unit_kind      <= 6'd0;
      payload_count  <= 2'd0;
      slice_flag_bit <= 1'b0;
    end else if (go) begin
      byte_offset    <= byte_offset_next;
      zero_run       <= zero_run_next;
      pending_code   <= pending_code_next;
      pending_start  <= pending_start_next;
      pending_prefix <= pending_prefix_next;
      unit_active    <= unit_active_next;
      unit_start     <= unit_start_next;
      unit_prefix    <= unit_prefix_next;
      unit_kind      <= unit_kind_next;
      payload_count  <= payload_count_next;
      slice_flag_bit <= slice_flag_bit_next;
    end
  end

endmodule

>>> sv/hevcnal_fifo.sv
// four-entry record queue, up to two writes and one read per cycle
// depends on hevcnal_pkg
module hevcnal_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  hevcnal_pkg::rec_push_t push_a,
  input  hevcnal_pkg::rec_push_t push_b,
  output logic                   room2,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output hevcnal_pkg::rec_t      pop_rec
);
  import hevcnal_pkg::*;

  rec_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [1:0] n_push;
  rec_t       first;

  always_comb begin
    pop       = pop_valid && pop_ready;
    n_push    = {1'b0, push_a.valid} + {1'b0, push_b.valid};
    first     = push_a.valid ? push_a.rec : push_b.rec;
    room2     = (count <= 3'd2);
    pop_valid = (count != 3'd0);
    pop_rec   = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push_b.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

>>> sv/hevc_annexb_nal_splitter_top.sv
// top level of the annex b nal splitter: input beat register, scanner, record queue
// depends on hevcnal_pkg, hevcnal_scan, hevcnal_fifo
//
// Takes one stream byte per beat, with last_byte marking the final byte of a
// buffer, and delivers one record per completed nal unit (offset, size, start
// code length, type and flags). One byte is taken every cycle while the record
// queue has room for two records; the scanner lies between the input register
// and the four-entry record queue. A buffer's final byte may yield two records,
// the first with end_of_buffer low. Records leave one per cycle while out_ready
// is high. Offsets and sizes wrap at 2^32. Bytes before the first start code
// give no record.
module hevc_annexb_nal_splitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] unit_offset,
  output logic [31:0] unit_size,
  output logic [2:0]  prefix_len,
  output logic [5:0]  unit_type,
  output logic        is_param_set,
  output logic        is_key_frame,
  output logic        is_first_slice,
  output logic        at_buffer_start,
  output logic        end_of_buffer
);
  import hevcnal_pkg::*;

  logic      hold_valid;
  logic [7:0] hold_byte;
  logic      hold_last;
  logic      go;
  logic      room2;
  rec_push_t push_a, push_b;
  rec_t      pop_rec;

  assign go       = hold_valid && room2;
  assign in_ready = !hold_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  hevcnal_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .data_byte (hold_byte),
    .last_byte (hold_last),
    .push_a    (push_a),
    .push_b    (push_b)
  );

  hevcnal_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .push_b    (push_b),
    .room2     (room2),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_rec   (pop_rec)
  );

  assign unit_offset     = pop_rec.unit_offset;
  assign unit_size       = pop_rec.unit_size;
  assign prefix_len      = pop_rec.prefix_len;
  assign unit_type       = pop_rec.unit_type;
  assign is_param_set    = pop_rec.is_param_set;
  assign is_key_frame    = pop_rec.is_key_frame;
  assign is_first_slice  = pop_rec.is_first_slice;
  assign at_buffer_start = pop_rec.at_buffer_start;
  assign end_of_buffer   = pop_rec.end_of_buffer;

endmodule
